// ----- design/cckb_pkg.sv -----
// shared types and constants of the clipped color-key blitter for 4-bit pixels
// no dependencies; imported by every module of the block
`default_nettype none

package cckb_pkg;

    // fixed field widths
    localparam int CFG_W       = 11;
    localparam int CIDX_W      = 3;
    localparam int ADDR_W      = 19;
    localparam int SRC_TDATA_W = 8;
    localparam int DST_TDATA_W = 32;
    localparam int POS_W       = 13;

    // default size limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // transparent key and nibble enable codes
    localparam logic [3:0] KEY_PIXEL = 4'hd;
    localparam logic [1:0] EN_LOW    = 2'b01;
    localparam logic [1:0] EN_HIGH   = 2'b10;

    // register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_DEST_WIDTH  = 3'd0,
        REG_DEST_HEIGHT = 3'd1,
        REG_SRC_WIDTH   = 3'd2,
        REG_SRC_HEIGHT  = 3'd3,
        REG_POS_X       = 3'd4,
        REG_POS_Y       = 3'd5
    } t_reg_idx;

    // active configuration with derived row strides in bytes
    typedef struct packed {
        logic [CFG_W-1:0]        dest_width;
        logic [CFG_W-1:0]        dest_height;
        logic [CFG_W-1:0]        src_width;
        logic [CFG_W-1:0]        src_height;
        logic signed [CFG_W-1:0] pos_x;
        logic signed [CFG_W-1:0] pos_y;
        logic [CFG_W-1:0]        dest_stride;
        logic [CFG_W-1:0]        src_stride;
    } t_cfg;

    // one source word with its row already resolved
    typedef struct packed {
        logic [7:0]        src_byte;
        logic [CFG_W-1:0]  col;
        logic              row_ok;
        logic [ADDR_W-1:0] row_base;
    } t_item;

    // one destination write
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [1:0]        en;
        logic              last;
    } t_wr;

endpackage

`default_nettype wire

// ----- design/cckb_cfg.sv -----
// configuration registers with size clamping and row stride derivation
// depends on cckb_pkg
`default_nettype none

module cckb_cfg #(
    parameter int MAX_WIDTH  = cckb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cckb_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [cckb_pkg::CIDX_W-1:0]  i_cfg_index,
    input  wire logic [cckb_pkg::CFG_W-1:0]   i_cfg_wdata,
    output cckb_pkg::t_cfg                    o_cfg
);
    import cckb_pkg::*;

    // limits as register values; an 11-bit value never exceeds 2047
    localparam logic [CFG_W-1:0] W_LIM =
        (MAX_WIDTH > 2047) ? {CFG_W{1'b1}} : CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] H_LIM =
        (MAX_HEIGHT > 2047) ? {CFG_W{1'b1}} : CFG_W'(MAX_HEIGHT);

    logic [CFG_W-1:0] r_dest_width, r_dest_height, r_src_width, r_src_height;
    logic [CFG_W-1:0] r_pos_x, r_pos_y;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] x,
                                                    input logic [CFG_W-1:0] lim);
        logic [CFG_W-1:0] y;
        if (x == '0) begin
            y = CFG_W'(1);
        end else if (x > lim) begin
            y = lim;
        end else begin
            y = x;
        end
        return y;
    endfunction

    // padded stride: 4 bytes per 8 pixels
    function automatic logic [CFG_W-1:0] stride_of(input logic [CFG_W-1:0] w);
        logic [CFG_W:0] s;
        s = (CFG_W+1)'(w) + (CFG_W+1)'(7);
        return {s[CFG_W:3], 2'b00};
    endfunction

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_width  <= CFG_W'(1);
            r_dest_height <= CFG_W'(1);
            r_src_width   <= CFG_W'(1);
            r_src_height  <= CFG_W'(1);
            r_pos_x       <= '0;
            r_pos_y       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEST_WIDTH:  r_dest_width  <= clamp_size(i_cfg_wdata, W_LIM);
                REG_DEST_HEIGHT: r_dest_height <= clamp_size(i_cfg_wdata, H_LIM);
                REG_SRC_WIDTH:   r_src_width   <= clamp_size(i_cfg_wdata, W_LIM);
                REG_SRC_HEIGHT:  r_src_height  <= clamp_size(i_cfg_wdata, H_LIM);
                REG_POS_X:       r_pos_x       <= i_cfg_wdata;
                REG_POS_Y:       r_pos_y       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_cfg.dest_width  = r_dest_width;
        o_cfg.dest_height = r_dest_height;
        o_cfg.src_width   = r_src_width;
        o_cfg.src_height  = r_src_height;
        o_cfg.pos_x       = r_pos_x;
        o_cfg.pos_y       = r_pos_y;
        o_cfg.dest_stride = stride_of(r_dest_width);
        o_cfg.src_stride  = stride_of(r_src_width);
    end

endmodule

`default_nettype wire

// ----- design/cckb_walk.sv -----
// source position counters, row clipping and the input word register
// depends on cckb_pkg
`default_nettype none

module cckb_walk #(
    parameter int MAX_WIDTH  = cckb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cckb_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire cckb_pkg::t_cfg                    i_cfg,
    input  wire logic                              i_valid,
    input  wire logic [7:0]                        i_byte,
    input  wire logic                              i_first,
    output logic                                   o_ready,
    input  wire logic                              i_advance,
    output logic                                   o_valid,
    output cckb_pkg::t_item                        o_item
);
    import cckb_pkg::*;

    // counter ranges follow from the size limits, capped at what 11 bits can hold
    localparam int W_EFF = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
    localparam int H_EFF = (MAX_HEIGHT > 2047) ? 2047 : MAX_HEIGHT;
    localparam int SMAX  = ((4 * W_EFF + 31) >> 5) << 2;
    localparam int BIR_W = $clog2(SMAX);
    localparam int RW    = $clog2(H_EFF);
    localparam int CW1   = CFG_W + 1;

    logic             r_v;
    logic [BIR_W-1:0] r_bir;
    logic [RW-1:0]    r_row;
    t_item            r_item;

    logic             accept;
    logic [BIR_W-1:0] eff_bir;
    logic [RW-1:0]    eff_row;
    logic             bir_wrap, row_wrap;
    logic signed [POS_W-1:0] dy;
    logic             row_ok;
    logic [2*CFG_W-1:0] prod;
    t_item            n_item;

    assign o_ready = !r_v || i_advance;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_v;
    assign o_item  = r_item;

    // position of this word, restarted by a first-of-image flag
    always_comb begin
        eff_bir  = i_first ? '0 : r_bir;
        eff_row  = i_first ? '0 : r_row;
        bir_wrap = (CW1'(eff_bir) + CW1'(1)) >= CW1'(i_cfg.src_stride);
        row_wrap = (CW1'(eff_row) + CW1'(1)) >= CW1'(i_cfg.src_height);
    end

    // destination row and its byte offset
    always_comb begin
        dy = $signed({{(POS_W-CFG_W){i_cfg.pos_y[CFG_W-1]}}, i_cfg.pos_y})
             + $signed(POS_W'(eff_row));
        row_ok = (CW1'(eff_row) < CW1'(i_cfg.src_height)) && !dy[POS_W-1]
                 && ((POS_W-1)'(dy[POS_W-2:0]) < (POS_W-1)'(i_cfg.dest_height));
        prod = (2*CFG_W)'(dy[CFG_W-1:0]) * (2*CFG_W)'(i_cfg.dest_stride);
        n_item.src_byte = i_byte;
        n_item.col      = CFG_W'({eff_bir, 1'b0});
        n_item.row_ok   = row_ok;
        n_item.row_base = row_ok ? prod[ADDR_W-1:0] : '0;
    end

    // counters and word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_bir <= '0;
            r_row <= '0;
        end else begin
            if (accept) begin
                r_v <= 1'b1;
                if (bir_wrap) begin
                    r_bir <= '0;
                    r_row <= row_wrap ? '0 : eff_row + RW'(1);
                end else begin
                    r_bir <= eff_bir + BIR_W'(1);
                    r_row <= eff_row;
                end
            end else if (i_advance) begin
                r_v <= 1'b0;
            end
        end
    end

    // word payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/cckb_pix.sv -----
// per-pixel column clipping, color key test and write formation
// depends on cckb_pkg
`default_nettype none

module cckb_pix (
    input  wire cckb_pkg::t_cfg   i_cfg,
    input  wire cckb_pkg::t_item  i_item,
    output cckb_pkg::t_wr         o_w0,
    output cckb_pkg::t_wr         o_w1,
    output logic [1:0]            o_cnt
);
    import cckb_pkg::*;

    logic [3:0]              pix0, pix1;
    logic [CFG_W-1:0]        c0, c1;
    logic signed [POS_W-1:0] dx0, dx1, dxs;
    logic                    ok0, ok1;
    logic [ADDR_W-1:0]       a0, a1, as;
    t_wr                     wa, wb;

    function automatic logic col_ok(input logic [CFG_W-1:0] c,
                                    input logic signed [POS_W-1:0] dx,
                                    input logic [3:0] p,
                                    input t_cfg cfg,
                                    input logic row_ok);
        return row_ok && (c < cfg.src_width) && !dx[POS_W-1]
               && ((POS_W-1)'(dx[POS_W-2:0]) < (POS_W-1)'(cfg.dest_width))
               && (p != KEY_PIXEL);
    endfunction

    // left and right pixel positions
    always_comb begin
        pix0 = i_item.src_byte[7:4];
        pix1 = i_item.src_byte[3:0];
        c0   = i_item.col;
        c1   = i_item.col | CFG_W'(1);
        dx0  = $signed({{(POS_W-CFG_W){i_cfg.pos_x[CFG_W-1]}}, i_cfg.pos_x})
               + $signed(POS_W'(c0));
        dx1  = dx0 + POS_W'(1);
        ok0  = col_ok(c0, dx0, pix0, i_cfg, i_item.row_ok);
        ok1  = col_ok(c1, dx1, pix1, i_cfg, i_item.row_ok);
        a0   = i_item.row_base + ADDR_W'(dx0[POS_W-2:1]);
        a1   = i_item.row_base + ADDR_W'(dx1[POS_W-2:1]);
        dxs  = ok0 ? dx0 : dx1;
        as   = i_item.row_base + ADDR_W'(dxs[POS_W-2:1]);
    end

    // odd alignment: each pixel lands in its own byte
    always_comb begin
        wa.addr = a0;
        wa.data = {4'h0, pix0};
        wa.en   = EN_LOW;
        wa.last = 1'b1;
        wb.addr = a1;
        wb.data = {pix1, 4'h0};
        wb.en   = EN_HIGH;
        wb.last = 1'b1;
    end

    // select writes by alignment
    always_comb begin
        o_w0 = wa;
        o_w1 = wb;
        o_cnt = 2'd0;
        if (!i_cfg.pos_x[0]) begin
            // even alignment: both pixels merge into one byte
            o_w0.addr = as;
            o_w0.data = {ok0 ? pix0 : 4'h0, ok1 ? pix1 : 4'h0};
            o_w0.en   = {ok0, ok1};
            o_w0.last = 1'b1;
            o_cnt     = (ok0 || ok1) ? 2'd1 : 2'd0;
        end else begin
            priority if (ok0 && ok1) begin
                o_w0.last = 1'b0;
                o_cnt     = 2'd2;
            end else if (ok0) begin
                o_cnt = 2'd1;
            end else if (ok1) begin
                o_w0  = wb;
                o_cnt = 2'd1;
            end else begin
                o_cnt = 2'd0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/cckb_outq.sv -----
// two-entry result queue that hands destination writes out one word a cycle while m_axis is ready
// depends on cckb_pkg
`default_nettype none

module cckb_outq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire cckb_pkg::t_wr  i_w0,
    input  wire cckb_pkg::t_wr  i_w1,
    input  wire logic [1:0]     i_cnt,
    output logic                o_can_load,
    output logic                o_valid,
    input  wire logic           i_ready,
    output cckb_pkg::t_wr       o_word
);
    import cckb_pkg::*;

    logic [1:0] r_cnt;
    t_wr        r_q0, r_q1;
    logic       fire, load;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_word     = r_q0;
    assign fire       = o_valid && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign load       = i_load && o_can_load;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (load) begin
            r_cnt <= i_cnt;
        end else if (fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // entries
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_q0 <= i_w0;
            r_q1 <= i_w1;
        end else if (fire) begin
            r_q0 <= r_q1;
        end
    end

endmodule

`default_nettype wire

// ----- design/clipped_color_key_blit_4bpp_unit.sv -----
// top level of the clipped color-key blitter for packed 4-bit pixels
// depends on cckb_pkg, cckb_cfg, cckb_walk, cckb_pix, cckb_outq
//
//  channel   | direction | handshake            | payload
//  s_axis    | in        | tvalid / tready      | tdata[7:0] source byte, tuser first of image
//  m_axis    | out       | tvalid / tready      | tdata address, data, enables; tlast
//  cfg       | in        | we, no back-pressure | index, wdata
//
// a source word is taken every cycle while the result queue keeps up; a word that
// gives two writes (odd pos_x, both pixels drawn) holds the next word back until
// its second write is leaving, since the single destination write port sends one write
// at a time. a write passes the input register and then the result queue before it
// is offered on m_axis.
// synchronous active-low reset clears the counters, the queue occupancy and the configuration registers to their
// reset values; a stalled m_axis holds its word and backs up into s_axis.
`default_nettype none

module clipped_color_key_blit_4bpp_unit #(
    parameter int MAX_WIDTH  = cckb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cckb_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [cckb_pkg::CIDX_W-1:0]        i_cfg_index,
    input  wire logic [cckb_pkg::CFG_W-1:0]         i_cfg_wdata,
    // source stream
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [cckb_pkg::SRC_TDATA_W-1:0]   i_s_axis_tdata,  // [7:0] source_byte
    input  wire logic                               i_s_axis_tuser,  // [0] first_of_image
    // destination writes
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [18:0] dest_address, [26:19] write_data, [28:27] nibble_enable, [31:29] zero
    output logic [cckb_pkg::DST_TDATA_W-1:0]        o_m_axis_tdata,
    output logic                                    o_m_axis_tlast   // last_of_run
);
    import cckb_pkg::*;

    t_cfg       cfg;
    t_item      item;
    logic       item_v;
    logic       can_load;
    t_wr        w0, w1, word;
    logic [1:0] wcnt;

    // configuration registers
    cckb_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // source walk and input register
    cckb_walk #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (i_s_axis_tvalid),
        .i_byte    (i_s_axis_tdata[7:0]),
        .i_first   (i_s_axis_tuser),
        .o_ready   (o_s_axis_tready),
        .i_advance (can_load),
        .o_valid   (item_v),
        .o_item    (item)
    );

    // pixel tests and write formation
    cckb_pix u_pix (
        .i_cfg  (cfg),
        .i_item (item),
        .o_w0   (w0),
        .o_w1   (w1),
        .o_cnt  (wcnt)
    );

    // result queue
    cckb_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (item_v),
        .i_w0       (w0),
        .i_w1       (w1),
        .i_cnt      (wcnt),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_word     (word)
    );

    // output packing
    assign o_m_axis_tdata = {(DST_TDATA_W-ADDR_W-10)'(0), word.en, word.data, word.addr};
    assign o_m_axis_tlast = word.last;

endmodule

`default_nettype wire

// ----- tb/sv/tb_clipped_color_key_blit_4bpp_unit.sv -----
// self-checking testbench for clipped_color_key_blit_4bpp_unit: streams source bytes,
// predicts every destination write in place and compares each write field by field
// depends on cckb_pkg and the clipped_color_key_blit_4bpp_unit rtl
module tb_clipped_color_key_blit_4bpp_unit;
    import cckb_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_TAIL  = 8;
    localparam int END_TAIL    = 20;
    localparam int LONG_HOLD   = 300;
    localparam int SIZE_MAX    = MAX_WIDTH_DEF;
    localparam int ROWS_MAX    = MAX_HEIGHT_DEF;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [SRC_TDATA_W-1:0] i_s_axis_tdata = '0;   // [7:0] source_byte
    logic                   i_s_axis_tuser = 1'b0; // [0] first_of_image
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [18:0] dest_address, [26:19] write_data, [28:27] nibble_enable, [31:29] zero
    logic [DST_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;        // last_of_run

    clipped_color_key_blit_4bpp_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // blit geometry as the block holds it after clamping
    int geo_dst_w = 1;
    int geo_dst_h = 1;
    int geo_src_w = 1;
    int geo_src_h = 1;
    int geo_pos_x = 0;
    int geo_pos_y = 0;
    // position of the next source byte in the padded source
    int walk_col_byte = 0;
    int walk_row = 0;

    t_wr pending_writes[$];
    bit  idle_on = 1'b1;
    int  hold_asks = 0;
    int  mismatches = 0;
    int  writes_checked = 0;
    int  words_sent = 0;
    int  settings_used = 0;

    // size registers: zero acts as one, above the limit acts as the limit
    function automatic int clamp_size(logic [CFG_W-1:0] v, int maxv);
        if (v == '0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    // padded row stride in bytes for a width in 4-bit pixels
    function automatic int row_stride(int w);
        return ((w * 4 + 31) >> 5) << 2;
    endfunction

    function automatic void apply_reg(t_reg_idx idx, logic [CFG_W-1:0] v);
        case (idx)
            REG_DEST_WIDTH:  geo_dst_w = clamp_size(v, SIZE_MAX);
            REG_DEST_HEIGHT: geo_dst_h = clamp_size(v, ROWS_MAX);
            REG_SRC_WIDTH:   geo_src_w = clamp_size(v, SIZE_MAX);
            REG_SRC_HEIGHT:  geo_src_h = clamp_size(v, ROWS_MAX);
            REG_POS_X:       geo_pos_x = $signed(v);
            REG_POS_Y:       geo_pos_y = $signed(v);
            default: ;
        endcase
    endfunction

    // queue the destination writes that one source byte causes, then step the walk
    function automatic void blit_byte_writes(logic [7:0] b, logic first_flag);
        int          sstride;
        int          dstride;
        int          dy;
        int          col;
        int          dx_hi;
        int          dx_lo;
        bit          row_ok;
        bit          ok_hi;
        bit          ok_lo;
        logic [3:0]  pix_hi;
        logic [3:0]  pix_lo;
        logic [31:0] base;
        t_wr         w;

        if (first_flag) begin
            walk_col_byte = 0;
            walk_row = 0;
        end
        sstride = row_stride(geo_src_w);
        dstride = row_stride(geo_dst_w);
        dy = geo_pos_y + walk_row;
        row_ok = walk_row < geo_src_h && dy >= 0 && dy < geo_dst_h;
        base = row_ok ? (dy * dstride) & 32'h1f_ffff : 32'd0;
        pix_hi = b[7:4];
        pix_lo = b[3:0];
        col = 2 * walk_col_byte;
        dx_hi = geo_pos_x + col;
        dx_lo = dx_hi + 1;
        // each pixel clipped alone against the source and destination edges, key pixels dropped
        ok_hi = row_ok && col < geo_src_w && dx_hi >= 0 && dx_hi < geo_dst_w &&
                pix_hi != KEY_PIXEL;
        ok_lo = row_ok && col + 1 < geo_src_w && dx_lo >= 0 && dx_lo < geo_dst_w &&
                pix_lo != KEY_PIXEL;

        if (geo_pos_x[0] == 1'b0) begin
            // even offset: both pixels share one destination byte
            if (ok_hi || ok_lo) begin
                w.addr = ADDR_W'(base + ((ok_hi ? dx_hi : dx_lo) >> 1));
                w.data = {ok_hi ? pix_hi : 4'h0, ok_lo ? pix_lo : 4'h0};
                w.en   = {ok_hi, ok_lo};
                w.last = 1'b1;
                pending_writes.push_back(w);
            end
        end else begin
            // odd offset: left pixel lands low, right pixel high in the next byte
            if (ok_hi) begin
                w.addr = ADDR_W'(base + (dx_hi >> 1));
                w.data = {4'h0, pix_hi};
                w.en   = EN_LOW;
                w.last = !ok_lo;
                pending_writes.push_back(w);
            end
            if (ok_lo) begin
                w.addr = ADDR_W'(base + (dx_lo >> 1));
                w.data = {pix_lo, 4'h0};
                w.en   = EN_HIGH;
                w.last = 1'b1;
                pending_writes.push_back(w);
            end
        end

        // walk to the next byte, wrapping rows and the image
        if (walk_col_byte + 1 >= sstride) begin
            walk_col_byte = 0;
            walk_row = (walk_row + 1 >= geo_src_h) ? 0 : walk_row + 1;
        end else begin
            walk_col_byte++;
        end
    endfunction

    function automatic void log_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    // result side: compare every accepted write with the oldest expectation
    always @(posedge i_clk) begin : write_monitor
        t_wr want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            writes_checked++;
            if (pending_writes.size() == 0) begin
                log_mismatch($sformatf("unexpected write addr %h data %h en %b last %b",
                    o_m_axis_tdata[18:0], o_m_axis_tdata[26:19], o_m_axis_tdata[28:27],
                    o_m_axis_tlast));
            end else begin
                want = pending_writes.pop_front();
                if (o_m_axis_tdata[18:0] !== want.addr || o_m_axis_tdata[26:19] !== want.data ||
                    o_m_axis_tdata[28:27] !== want.en || o_m_axis_tdata[31:29] !== 3'b000 ||
                    o_m_axis_tlast !== want.last) begin
                    log_mismatch($sformatf(
                        "write %0d expected addr %h data %h en %b last %b, got %h %h %b %b pad %b",
                        writes_checked, want.addr, want.data, want.en, want.last,
                        o_m_axis_tdata[18:0], o_m_axis_tdata[26:19], o_m_axis_tdata[28:27],
                        o_m_axis_tlast, o_m_axis_tdata[31:29]));
                end
            end
        end
    end

    // result side ready: random stall bursts plus an occasional long hold
    always @(posedge i_clk) begin : sink_pacing
        int stall_left = 0;
        int hold_left = 0;
        int hold_seen = 0;
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // run limit
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // offer one source word, sometimes with a random gap first, and wait for it to be taken
    task automatic send_word(logic [7:0] b, logic first_flag);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= first_flag;
        do @(posedge i_clk); while (!o_s_axis_tready);
        blit_byte_writes(b, first_flag);
        words_sent++;
    endtask

    // stop sending and let every expected write come out
    task automatic drain_writes();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_writes.size() != 0);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        apply_reg(idx, v);
    endtask

    task automatic set_geometry(logic [CFG_W-1:0] dw, logic [CFG_W-1:0] dh,
                                logic [CFG_W-1:0] sw, logic [CFG_W-1:0] sh,
                                logic [CFG_W-1:0] px, logic [CFG_W-1:0] py);
        logic [CFG_W-1:0] vals[6];
        vals = '{dw, dh, sw, sh, px, py};
        for (int i = 0; i < 6; i++) write_reg(t_reg_idx'(i), vals[i]);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // pixels lean toward the transparent key
    function automatic logic [7:0] random_byte();
        logic [3:0] hi;
        logic [3:0] lo;
        hi = ($urandom_range(0, 4) == 0) ? KEY_PIXEL : 4'($urandom_range(0, 15));
        lo = ($urandom_range(0, 4) == 0) ? KEY_PIXEL : 4'($urandom_range(0, 15));
        return {hi, lo};
    endfunction

    // mostly small sizes, sometimes zero, the limit, past the limit or anything
    function automatic logic [CFG_W-1:0] pick_size(int typical);
        case ($urandom_range(0, 19))
            0: return '0;
            1: return CFG_W'(SIZE_MAX);
            2: return CFG_W'($urandom_range(SIZE_MAX + 1, 2047));
            3: return CFG_W'($urandom_range(0, 2047));
            default: return CFG_W'($urandom_range(1, typical));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_pos(int span);
        case ($urandom_range(0, 19))
            0: return 11'h400;
            1: return 11'h3ff;
            2: return CFG_W'($urandom_range(0, 2047));
            default: return CFG_W'(int'($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    // one random setting, then whole images with random content, some broken
    task automatic run_random_setting(int word_cap);
        int   total;
        int   img_words;
        logic first_flag;
        drain_writes();
        if ($urandom_range(0, 7) == 0) begin
            // far corner of a full-size destination
            set_geometry(CFG_W'(SIZE_MAX), CFG_W'(ROWS_MAX), CFG_W'($urandom_range(1, 16)),
                         CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(0, 1023)),
                         CFG_W'($urandom_range(0, 1023)));
        end else begin
            set_geometry(pick_size(40), pick_size(12), pick_size(40), pick_size(8),
                         pick_pos(16), pick_pos(8));
        end
        total = 0;
        while (total < word_cap) begin
            img_words = row_stride(geo_src_w) * geo_src_h;
            if ($urandom_range(0, 9) == 0) img_words = $urandom_range(1, img_words);
            if (img_words > word_cap - total) img_words = word_cap - total;
            for (int k = 0; k < img_words; k++) begin
                first_flag = (k == 0) ? ($urandom_range(0, 15) != 0)
                                      : ($urandom_range(0, 59) == 0);
                send_word(random_byte(), first_flag);
            end
            total += img_words;
        end
    endtask

    // defaults after reset: 1x1 destination and source at the origin, row padding
    task automatic test_reset_state();
        send_word(8'h12, 1'b1);
        send_word(8'hd3, 1'b0);
        send_word(8'hff, 1'b0);
    endtask

    // left edge with odd offset, key in both nibbles, right and bottom edges
    task automatic test_clip_and_key();
        logic [7:0] row0[8];
        drain_writes();
        set_geometry(11'd8, 11'd4, 11'd5, 11'd3, 11'h7ff, 11'd0);
        send_word(8'hab, 1'b1);
        send_word(8'hdc, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h77, 1'b0);
        drain_writes();
        set_geometry(11'd8, 11'd4, 11'd9, 11'd3, 11'd4, 11'd3);
        row0 = '{8'h12, 8'hd4, 8'h56, 8'h00, 8'hff, 8'h9a, 8'hbc, 8'h3d};
        for (int k = 0; k < 8; k++) send_word(row0[k], k == 0);
        // second row falls below the destination
        for (int k = 0; k < 5; k++) send_word(8'h11, 1'b0);
    endtask

    // walk left past a shrunk stride and height, then extreme register values
    task automatic test_walk_corners();
        drain_writes();
        write_reg(REG_SRC_WIDTH, 11'd1);
        write_reg(REG_SRC_HEIGHT, 11'd1);
        i_cfg_we <= 1'b0;
        send_word(8'hee, 1'b0);
        send_word(8'h8d, 1'b0);
        drain_writes();
        set_geometry(11'd2047, 11'd0, 11'd0, 11'd2047, 11'd1023, 11'd0);
        send_word(8'h9c, 1'b1);
        drain_writes();
        write_reg(REG_POS_X, 11'h400);
        write_reg(REG_POS_Y, 11'h400);
        i_cfg_we <= 1'b0;
        send_word(8'hff, 1'b1);
    endtask

    // long hold on the write side while words keep coming, then a full pause
    task automatic test_back_pressure();
        drain_writes();
        set_geometry(11'd40, 11'd12, 11'd16, 11'd6, 11'd3, 11'd1);
        hold_asks++;
        for (int k = 0; k < 60; k++) send_word(random_byte(), k == 0);
        drain_writes();
        for (int k = 0; k < 30; k++) send_word(random_byte(), 1'b0);
    endtask

    task automatic test_random_images();
        while (words_sent < 1050) run_random_setting($urandom_range(20, 100));
    endtask

    // full rate on both sides
    task automatic test_steady_stream();
        idle_on = 1'b0;
        while (words_sent < 1300) run_random_setting($urandom_range(40, 100));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_clip_and_key();
        test_walk_corners();
        test_back_pressure();
        test_random_images();
        test_steady_stream();
        drain_writes();
        repeat (END_TAIL) @(posedge i_clk);
        $display("covered %0d source words over %0d register settings, %0d writes checked",
                 words_sent, settings_used, writes_checked);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
